// ----- rtl/fcmw_pkg.sv -----
// ----------------------------------------------------------------------------
// fcmw_pkg
// Types, register map and modular add helpers for the multiwidth Fletcher unit.
// ----------------------------------------------------------------------------
package fcmw_pkg;

	// variant select codes
	typedef enum logic [1:0] {
		MODE_8  = 2'd0,
		MODE_16 = 2'd1,
		MODE_32 = 2'd2,
		MODE_64 = 2'd3
	} width_mode_t;

	// register map, decoded on the word address bit
	localparam logic REG_WIDTH_MODE = 1'b0;

	localparam width_mode_t MODE_RESET = MODE_16;

	localparam logic [8:0]  MOD8  = 9'd255;
	localparam logic [16:0] MOD16 = 17'd65535;

	// end-around carry add, result stays within 9 bits
	function automatic logic [8:0] fold8_add(input logic [8:0] a, input logic [7:0] b);
		logic [9:0] s;
		s = {1'b0, a} + {2'b00, b};
		return {1'b0, s[7:0]} + {7'b0, s[9:8]};
	endfunction

	// add modulo 255, a below 255
	function automatic logic [7:0] mod255_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= MOD8)
			s = s - MOD8;
		return s[7:0];
	endfunction

	// add modulo 65535, a below 65535
	function automatic logic [15:0] mod65535_add(input logic [15:0] a,
		input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= MOD16)
			s = s - MOD16;
		return s[15:0];
	endfunction

endpackage

// ----- rtl/fletcher_checksum_multiwidth_unit.sv -----
// Pipeline: a byte beat is held in the input stage register; when it leaves
// that stage its sums update the running sums, or for a final byte its
// checksum is loaded into the output register. Throughput: one byte beat per
// cycle; a final beat stalls only while the output register is still full.
// Reset: width_mode returns to sixteen-bit, all sums and the partial word clear.
// ----------------------------------------------------------------------------
// fletcher_checksum_multiwidth_unit
// Streaming Fletcher-16/32 checksum, plus 8-bit and mod-2^32 64-bit variants;
// one byte per beat, little-endian words, zero-padded tail, APB mode register.
// ----------------------------------------------------------------------------
module fletcher_checksum_multiwidth_unit
	import fcmw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// byte stream
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	// checksum result
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] checksum,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	width_mode_t mode_q;
	logic [31:0] first_q, second_q;
	logic [23:0] partial_q;
	logic [1:0]  pos_q;

	logic        valid_s1;
	logic [7:0]  data_byte_s1;
	logic        last_byte_s1;

	logic        out_valid_q;
	logic [63:0] checksum_q;

	logic        cfg_wr;
	logic        out_free;
	logic        fire_s1;
	logic        word_done;
	logic [31:0] word;
	logic [31:0] first_d, second_d;
	logic [63:0] checksum_d;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_WIDTH_MODE);
	assign prdata = (paddr[2] == REG_WIDTH_MODE) ? {30'b0, mode_q} : 32'b0;

	// handshake
	assign out_free  = ~out_valid_q | out_ready;
	assign fire_s1   = valid_s1 & (~last_byte_s1 | out_free);
	assign in_ready  = ~valid_s1 | fire_s1;
	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;

	// word assembly and completion
	always_comb begin
		word = {8'b0, partial_q} | (32'(data_byte_s1) << {pos_q, 3'b000});
		case (mode_q) inside
			MODE_8, MODE_16: word_done = 1'b1;
			MODE_32:         word_done = (pos_q == 2'd1) | last_byte_s1;
			MODE_64:         word_done = (pos_q == 2'd3) | last_byte_s1;
		endcase
	end

	// sum update
	always_comb begin
		first_d  = first_q;
		second_d = second_q;
		if (word_done) begin
			case (mode_q)
				MODE_8: begin
					first_d = {23'b0, fold8_add(first_q[8:0], word[7:0])};
				end
				MODE_16: begin
					first_d  = {24'b0, mod255_add(first_q[7:0], word[7:0])};
					second_d = {24'b0, mod255_add(second_q[7:0], first_d[7:0])};
				end
				MODE_32: begin
					first_d  = {16'b0, mod65535_add(first_q[15:0], word[15:0])};
					second_d = {16'b0, mod65535_add(second_q[15:0], first_d[15:0])};
				end
				MODE_64: begin
					first_d  = first_q + word;
					second_d = second_q + first_d;
				end
			endcase
		end
	end

	// result packing
	always_comb begin
		case (mode_q)
			MODE_8:  checksum_d = {56'b0, first_d[7:0]};
			MODE_16: checksum_d = {48'b0, second_d[7:0], first_d[7:0]};
			MODE_32: checksum_d = {32'b0, second_d[15:0], first_d[15:0]};
			MODE_64: checksum_d = {second_d, first_d};
		endcase
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_byte_s1 <= data_byte;
			last_byte_s1 <= last_byte;
		end
	end

	// mode register and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_RESET;
			first_q   <= '0;
			second_q  <= '0;
			partial_q <= '0;
			pos_q     <= '0;
		end else if (cfg_wr) begin
			mode_q    <= width_mode_t'(pwdata[1:0]);
			first_q   <= '0;
			second_q  <= '0;
			partial_q <= '0;
			pos_q     <= '0;
		end else if (fire_s1) begin
			if (last_byte_s1) begin
				first_q   <= '0;
				second_q  <= '0;
				partial_q <= '0;
				pos_q     <= '0;
			end else if (word_done) begin
				first_q   <= first_d;
				second_q  <= second_d;
				partial_q <= '0;
				pos_q     <= '0;
			end else begin
				partial_q <= word[23:0];
				pos_q     <= pos_q + 2'd1;
			end
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_byte_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire_s1 && last_byte_s1) begin
			checksum_q <= checksum_d;
		end
	end

	// byte position stays inside the word size of the mode
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		((mode_q == MODE_8 || mode_q == MODE_16) |-> pos_q == 2'd0) and
		((mode_q == MODE_32) |-> pos_q <= 2'd1))
		else $error("byte position beyond word size");

	// reduced sums stay below their modulus
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		((mode_q == MODE_16) |-> (first_q < 32'd255 && second_q < 32'd255)) and
		((mode_q == MODE_32) |-> (first_q < 32'd65535 && second_q < 32'd65535)))
		else $error("sum not reduced");

	// a final byte leaves the message state clear
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && last_byte_s1 |=>
		first_q == '0 && second_q == '0 && partial_q == '0 && pos_q == '0)
		else $error("message state not cleared after final byte");

	// the input side stalls only behind a final byte waiting on a full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && last_byte_s1 && out_valid_q && !out_ready)
		else $error("unexpected input stall");

endmodule
